@@ hw/rtl/sfcc_pkg.sv @@
// ----------------------------------------------------------------------------
// Serial frame CRC checker package
// Shared widths, register indexes, status codes and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package sfcc_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 9;
  localparam int unsigned CrcW     = 16;
  localparam int unsigned RegIdxW  = 2;
  localparam int unsigned CfgDataW = 9;

  localparam int unsigned MaxFrameDefault = 256;
  localparam int unsigned MinFrame        = 3;

  localparam logic [ByteW-1:0] HeaderFirstReset  = 8'd83;
  localparam logic [ByteW-1:0] HeaderSecondReset = 8'd80;
  localparam logic [LenW-1:0]  FrameLenReset     = 9'd32;

  localparam logic [CrcW-1:0] CrcStart = 16'hFFFF;
  localparam logic [CrcW-1:0] CrcPoly  = 16'h8408;

  // Configuration register indexes.
  localparam logic [RegIdxW-1:0] RegHeaderFirst  = 2'd0;
  localparam logic [RegIdxW-1:0] RegHeaderSecond = 2'd1;
  localparam logic [RegIdxW-1:0] RegFrameLength  = 2'd2;

  typedef enum logic [1:0] {
    StatusPending   = 2'd0,
    StatusOk        = 2'd1,
    StatusHeaderBad = 2'd2,
    StatusCrcBad    = 2'd3
  } status_e;

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [CrcW-1:0] crc16_byte(input logic [CrcW-1:0] crc,
                                                 input logic [ByteW-1:0] b);
    logic [CrcW-1:0] c;
    c = crc ^ {{(CrcW-ByteW){1'b0}}, b};
    for (int k = 0; k < ByteW; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/sfcc_rx_if.sv @@
// ----------------------------------------------------------------------------
// Received byte channel
// Valid/ready channel carrying one received byte and its frame start flag.
// ----------------------------------------------------------------------------
interface sfcc_rx_if import sfcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;
  logic             frame_start;

  modport source (output valid, output rx_byte, output frame_start, input ready);
  modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

@@ hw/rtl/sfcc_res_if.sv @@
// ----------------------------------------------------------------------------
// Checked byte channel
// Valid/ready channel carrying the passed-through byte, its index and status.
// ----------------------------------------------------------------------------
interface sfcc_res_if import sfcc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] out_byte;
  logic [ByteW-1:0] byte_index;
  logic             frame_end;
  status_e          frame_status;

  modport source (output valid, output out_byte, output byte_index, output frame_end,
                  output frame_status, input ready);
  modport sink   (input valid, input out_byte, input byte_index, input frame_end,
                  input frame_status, output ready);
endinterface

@@ hw/rtl/sfcc_cfg_if.sv @@
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface sfcc_cfg_if import sfcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RegIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ hw/rtl/serial_frame_crc_checker.sv @@
// ----------------------------------------------------------------------------
// Serial frame CRC checker
// Checks fixed-length frames byte by byte: header match, CRC-16 over the body
// and the little-endian CRC trailer; every byte is passed through with status.
// ----------------------------------------------------------------------------
// Output: the result word for an accepted word is registered and appears on res_o in the next cycle.
// Throughput: one word per cycle unless res_o holds off a pending result; the CRC byte update and
// the position compares sit between the frame state and the output register.
// Reset: asynchronous, active low; clears the frame state, the output valid
// and loads the configuration registers with their default values.
module serial_frame_crc_checker import sfcc_pkg::*; #(
  parameter int unsigned MAX_FRAME = MaxFrameDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sfcc_rx_if.sink    rx_i,
  sfcc_res_if.source res_o,
  sfcc_cfg_if.sink   cfg_i
);

  localparam int unsigned PosW = $clog2(MAX_FRAME);
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_FRAME);
  localparam logic [LenW-1:0] MinLen = LenW'(MinFrame);
  localparam logic [LenW-1:0] LenReset = (FrameLenReset > MaxLen) ? MaxLen : FrameLenReset;

  // Configuration registers; the length is saturated when written.
  logic [ByteW-1:0] hdr_first_q, hdr_second_q;
  logic [LenW-1:0]  len_q, len_wr;

  always_comb begin
    len_wr = cfg_i.data;
    if (len_wr < MinLen) begin
      len_wr = MinLen;
    end else if (len_wr > MaxLen) begin
      len_wr = MaxLen;
    end
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_first_q  <= HeaderFirstReset;
      hdr_second_q <= HeaderSecondReset;
      len_q        <= LenReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegHeaderFirst:  hdr_first_q  <= cfg_i.data[ByteW-1:0];
        RegHeaderSecond: hdr_second_q <= cfg_i.data[ByteW-1:0];
        RegFrameLength:  len_q        <= len_wr;
        default: ;
      endcase
    end
  end

  // Frame state.
  logic [CrcW-1:0]  crc_q, crc_d;
  logic [PosW-1:0]  pos_q, pos_d;
  logic             hdr_bad_q, hdr_bad_d;
  logic [ByteW-1:0] crc_low_q, crc_low_d;

  // Output register.
  logic             out_valid_q;
  logic [ByteW-1:0] out_byte_q, out_idx_q;
  logic             out_end_q;
  status_e          out_status_q, status_d;

  logic             rx_fire;
  logic             restart;
  logic [PosW-1:0]  pos_cur;
  logic [LenW:0]    pos_ext, len_ext;
  logic             in_body, is_crc_low, is_last;
  logic [CrcW-1:0]  crc_base;
  logic [CrcW-1:0]  crc_rx;

  assign rx_i.ready = !out_valid_q || res_o.ready;
  assign rx_fire    = rx_i.valid && rx_i.ready;

  always_comb begin
    len_ext = {1'b0, len_q};
    restart = rx_i.frame_start || ({{(LenW+1-PosW){1'b0}}, pos_q} >= len_ext);
    pos_cur = restart ? '0 : pos_q;
    pos_ext = {{(LenW+1-PosW){1'b0}}, pos_cur};

    in_body    = (pos_ext + (LenW+1)'(3)) <= len_ext;
    is_crc_low = (pos_ext + (LenW+1)'(2)) == len_ext;
    is_last    = (pos_ext + (LenW+1)'(1)) == len_ext;

    // The CRC and the header flag start over on the first byte of a frame.
    hdr_bad_d = hdr_bad_q;
    crc_base  = crc_q;
    if (pos_cur == '0) begin
      crc_base  = CrcStart;
      hdr_bad_d = (rx_i.rx_byte != hdr_first_q);
    end else if (pos_cur == PosW'(1)) begin
      hdr_bad_d = hdr_bad_q || (rx_i.rx_byte != hdr_second_q);
    end

    crc_d     = in_body ? crc16_byte(crc_base, rx_i.rx_byte) : crc_base;
    crc_low_d = is_crc_low ? rx_i.rx_byte : crc_low_q;
    crc_rx    = {rx_i.rx_byte, crc_low_q};

    status_d = StatusPending;
    if (is_last) begin
      if (hdr_bad_d) begin
        status_d = StatusHeaderBad;
      end else if (crc_rx != crc_d) begin
        status_d = StatusCrcBad;
      end else begin
        status_d = StatusOk;
      end
    end

    pos_d = is_last ? '0 : pos_cur + PosW'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CrcStart;
      pos_q       <= '0;
      hdr_bad_q   <= 1'b0;
      crc_low_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (rx_fire) begin
        crc_q     <= crc_d;
        pos_q     <= pos_d;
        hdr_bad_q <= hdr_bad_d;
        crc_low_q <= crc_low_d;
      end
      if (rx_i.ready) begin
        out_valid_q <= rx_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      out_byte_q   <= rx_i.rx_byte;
      out_idx_q    <= ByteW'(pos_cur);
      out_end_q    <= is_last;
      out_status_q <= status_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.out_byte     = out_byte_q;
  assign res_o.byte_index   = out_idx_q;
  assign res_o.frame_end    = out_end_q;
  assign res_o.frame_status = out_status_q;

endmodule
